// ===== rtl/rmc_pkg.sv =====
// shared types, codes and helpers for the rmc sentence parser
`default_nettype none
package rmc_pkg;

    localparam int MINUTE_DECIMALS = 5;
    localparam int FRAC_LIMIT      = 6;

    localparam logic [1:0] EV_CLR    = 2'd0;
    localparam logic [1:0] EV_COMMIT = 2'd1;
    localparam logic [1:0] EV_EMIT   = 2'd2;

    localparam logic [3:0] FLD_TIME   = 4'd1;
    localparam logic [3:0] FLD_STATUS = 4'd2;
    localparam logic [3:0] FLD_LAT    = 4'd3;
    localparam logic [3:0] FLD_NS     = 4'd4;
    localparam logic [3:0] FLD_LON    = 4'd5;
    localparam logic [3:0] FLD_EW     = 4'd6;
    localparam logic [3:0] FLD_SPEED  = 4'd7;
    localparam logic [3:0] FLD_COURSE = 4'd8;
    localparam logic [3:0] FLD_DATE   = 4'd9;
    localparam logic [3:0] FLD_MAGVAR = 4'd10;
    localparam logic [3:0] FLD_MAGEW  = 4'd11;
    localparam logic [3:0] FLD_IGNORE = 4'd15;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  field;
        logic [23:0] int_v;
        logic [3:0]  f1;
        logic [6:0]  f2;
        logic [9:0]  f3;
        logic [19:0] fm;
        logic        stat;
        logic        lat_s;
        logic        lon_w;
        logic        mv_w;
        logic [19:0] fval;
        logic [17:0] q100;
        logic [6:0]  rem;
        logic [26:0] y;
        logic [20:0] q60;
        logic [37:0] degm;
    } t_evt;

    function automatic logic [19:0] pow10(input logic [2:0] n);
        case (n)
            3'd0:    return 20'd1;
            3'd1:    return 20'd10;
            3'd2:    return 20'd100;
            3'd3:    return 20'd1000;
            3'd4:    return 20'd10000;
            3'd5:    return 20'd100000;
            3'd6:    return 20'd1000000;
            default: return 20'd0;
        endcase
    endfunction

    // weight of one fraction digit in a k-digit padded fraction
    function automatic logic [19:0] frac_add(input int k, input logic [2:0] fd,
                                             input logic [3:0] d);
        logic [19:0] w;
        w = pow10(3'(k - 1 - int'(fd)));
        if (int'(fd) < k) return 20'({16'd0, d} * w);
        return 20'd0;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/rmc_conv.sv =====
// conversion pipeline, result values and output register
`default_nettype none
module rmc_conv (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_evt_vld,
    input  wire rmc_pkg::t_evt i_evt,
    output logic               o_full,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic               o_fix_valid,
    output logic [17:0]        o_utc_hhmmss,
    output logic [18:0]        o_date_ddmmyy,
    output logic signed [27:0] o_latitude_udeg,
    output logic signed [28:0] o_longitude_udeg,
    output logic [19:0]        o_speed_mknots,
    output logic [15:0]        o_course_cdeg,
    output logic signed [11:0] o_magvar_ddeg
);
    import rmc_pkg::*;

    localparam logic [24:0] M100 = 25'd21474837;
    localparam logic [27:0] M60  = 28'd143165577;
    localparam logic [37:0] LAT_CAP = 38'd90000000;
    localparam logic [37:0] LON_CAP = 38'd180000000;

    t_evt       r_s1, r_s2, r_s3, r_s4, r_s5;
    t_evt       n_s2, n_s3, n_s4, n_s5;
    logic [5:1] r_v;
    logic [5:1] adv;

    logic [17:0] r_time;
    logic [18:0] r_date;
    logic [26:0] r_latm;
    logic [27:0] r_lonm;
    logic [19:0] r_spd;
    logic [15:0] r_crs;
    logic [10:0] r_mv;
    logic signed [27:0] r_hlat;
    logic signed [28:0] r_hlon;

    logic [17:0] n_time;
    logic [18:0] n_date;
    logic [26:0] n_latm;
    logic [27:0] n_lonm;
    logic [19:0] n_spd;
    logic [15:0] n_crs;
    logic [10:0] n_mv;
    logic signed [27:0] n_hlat;
    logic signed [28:0] n_hlon;

    logic        r_out_vld;
    logic        out_load;
    logic        apply;
    logic [48:0] p100;
    logic [33:0] spd_raw;
    logic [30:0] crs_raw;
    logic [27:0] mv_raw;
    logic [23:0] rem_full;
    logic [54:0] p60;
    logic [37:0] total;

    assign out_load = !r_out_vld || !i_stall;
    assign adv[5]   = !r_v[5] || (r_s5.kind != EV_EMIT) || out_load;
    assign adv[4]   = !r_v[4] || adv[5];
    assign adv[3]   = !r_v[3] || adv[4];
    assign adv[2]   = !r_v[2] || adv[3];
    assign adv[1]   = !r_v[1] || adv[2];
    assign o_full   = !adv[1];
    assign apply    = r_v[5] && adv[5];

    // degrees split and plain fields
    always_comb begin
        n_s2    = r_s1;
        p100    = 49'(r_s1.int_v) * 49'(M100);
        n_s2.q100 = p100[48:31];
        spd_raw = 34'(r_s1.int_v) * 34'd1000 + 34'(r_s1.f3);
        crs_raw = 31'(r_s1.int_v) * 31'd100 + 31'(r_s1.f2);
        mv_raw  = 28'(r_s1.int_v) * 28'd10 + 28'(r_s1.f1);
        case (r_s1.field)
            FLD_TIME:   n_s2.fval = (r_s1.int_v > 24'd235959) ? 20'd235959
                                                              : r_s1.int_v[19:0];
            FLD_DATE:   n_s2.fval = (r_s1.int_v > 24'd311299) ? 20'd311299
                                                              : r_s1.int_v[19:0];
            FLD_SPEED:  n_s2.fval = (spd_raw > 34'd999999) ? 20'd999999 : spd_raw[19:0];
            FLD_COURSE: n_s2.fval = (crs_raw > 31'd36000) ? 20'd36000 : crs_raw[19:0];
            FLD_MAGVAR: n_s2.fval = (mv_raw > 28'd1800) ? 20'd1800 : mv_raw[19:0];
            default:    n_s2.fval = 20'd0;
        endcase
    end

    always_comb begin
        n_s3     = r_s2;
        rem_full = r_s2.int_v - 24'(r_s2.q100) * 24'd100;
        n_s3.rem = rem_full[6:0];
    end

    always_comb begin
        n_s4   = r_s3;
        n_s4.y = 27'(r_s3.rem) * 27'd1000000
               + 27'(r_s3.fm) * 27'(pow10(3'(FRAC_LIMIT - MINUTE_DECIMALS)));
    end

    always_comb begin
        n_s5      = r_s4;
        p60       = 55'(r_s4.y) * 55'(M60);
        n_s5.q60  = p60[53:33];
        n_s5.degm = 38'(r_s4.q100) * 38'd1000000;
    end

    // field update and held position
    always_comb begin
        total  = r_s5.degm + 38'(r_s5.q60);
        n_time = r_time;
        n_date = r_date;
        n_latm = r_latm;
        n_lonm = r_lonm;
        n_spd  = r_spd;
        n_crs  = r_crs;
        n_mv   = r_mv;
        n_hlat = r_hlat;
        n_hlon = r_hlon;
        if (r_s5.kind == EV_CLR) begin
            n_time = '0;
            n_date = '0;
            n_latm = '0;
            n_lonm = '0;
            n_spd  = '0;
            n_crs  = '0;
            n_mv   = '0;
        end else begin
            case (r_s5.field)
                FLD_TIME:   n_time = r_s5.fval[17:0];
                FLD_LAT:    n_latm = (total > LAT_CAP) ? 27'(LAT_CAP) : total[26:0];
                FLD_LON:    n_lonm = (total > LON_CAP) ? 28'(LON_CAP) : total[27:0];
                FLD_SPEED:  n_spd  = r_s5.fval;
                FLD_COURSE: n_crs  = r_s5.fval[15:0];
                FLD_DATE:   n_date = r_s5.fval[18:0];
                FLD_MAGVAR: n_mv   = r_s5.fval[10:0];
                default:    n_time = r_time;
            endcase
            if (r_s5.kind == EV_EMIT && r_s5.stat) begin
                n_hlat = r_s5.lat_s ? -$signed({1'b0, n_latm}) : $signed({1'b0, n_latm});
                n_hlon = r_s5.lon_w ? -$signed({1'b0, n_lonm}) : $signed({1'b0, n_lonm});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v       <= '0;
            r_out_vld <= 1'b0;
            r_time    <= '0;
            r_date    <= '0;
            r_latm    <= '0;
            r_lonm    <= '0;
            r_spd     <= '0;
            r_crs     <= '0;
            r_mv      <= '0;
            r_hlat    <= '0;
            r_hlon    <= '0;
        end else begin
            if (adv[1]) r_v[1] <= i_evt_vld;
            if (adv[2]) r_v[2] <= r_v[1];
            if (adv[3]) r_v[3] <= r_v[2];
            if (adv[4]) r_v[4] <= r_v[3];
            if (adv[5]) r_v[5] <= r_v[4];
            if (apply) begin
                r_time <= n_time;
                r_date <= n_date;
                r_latm <= n_latm;
                r_lonm <= n_lonm;
                r_spd  <= n_spd;
                r_crs  <= n_crs;
                r_mv   <= n_mv;
                r_hlat <= n_hlat;
                r_hlon <= n_hlon;
            end
            if (out_load) r_out_vld <= apply && (r_s5.kind == EV_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) r_s1 <= i_evt;
        if (adv[2]) r_s2 <= n_s2;
        if (adv[3]) r_s3 <= n_s3;
        if (adv[4]) r_s4 <= n_s4;
        if (adv[5]) r_s5 <= n_s5;
        if (out_load && apply && r_s5.kind == EV_EMIT) begin
            o_fix_valid      <= r_s5.stat;
            o_utc_hhmmss     <= n_time;
            o_date_ddmmyy    <= n_date;
            o_latitude_udeg  <= n_hlat;
            o_longitude_udeg <= n_hlon;
            o_speed_mknots   <= n_spd;
            o_course_cdeg    <= n_crs;
            o_magvar_ddeg    <= r_s5.mv_w ? -$signed({1'b0, n_mv}) : $signed({1'b0, n_mv});
        end
    end

    assign o_valid = r_out_vld;

`ifndef NO_ASSERTIONS
    a_full_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> (r_v[1] && r_v[5] && r_out_vld && i_stall))
        else $error("pipeline stalls without a waiting result");
    a_lat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_latitude_udeg <= 28'sd90000000 && o_latitude_udeg >= -28'sd90000000))
        else $error("latitude out of range");
    a_lon_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_longitude_udeg <= 29'sd180000000
                     && o_longitude_udeg >= -29'sd180000000))
        else $error("longitude out of range");
    a_course_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_course_cdeg <= 16'd36000))
        else $error("course above cap");
`endif
endmodule
`default_nettype wire

// ===== rtl/nmea_rmc_sentence_parser.sv =====
// rmc sentence parser top level: byte tokenizer and field accumulators
//  channel | valid   | stall   | payload
//  input   | i_valid | o_stall | i_rx_byte
//  output  | o_valid | i_stall | o_fix_valid .. o_magvar_ddeg
// one byte accepted per cycle while o_stall is low; after the edge that accepts a line feed, its result
// passes through conversion stages two to five and then the output register
// synchronous active-low reset returns to idle and clears the held position
// o_stall rises only when the pipeline is full behind a stalled result
`default_nettype none
module nmea_rmc_sentence_parser (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [7:0]    i_rx_byte,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic               o_fix_valid,
    output logic [17:0]        o_utc_hhmmss,
    output logic [18:0]        o_date_ddmmyy,
    output logic signed [27:0] o_latitude_udeg,
    output logic signed [28:0] o_longitude_udeg,
    output logic [19:0]        o_speed_mknots,
    output logic [15:0]        o_course_cdeg,
    output logic signed [11:0] o_magvar_ddeg
);
    import rmc_pkg::*;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEAD   = 2'd1;
    localparam logic [1:0] PH_FIELDS = 2'd2;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [23:0] INT_CAP  = 24'hFFFFFF;

    logic [1:0]  r_phase, n_phase;
    logic [2:0]  r_hidx, n_hidx;
    logic        r_hmatch, n_hmatch;
    logic [3:0]  r_field, n_field;
    logic [23:0] r_int, n_int;
    logic        r_point, n_point;
    logic [2:0]  r_fdig, n_fdig;
    logic [3:0]  r_f1, n_f1;
    logic [6:0]  r_f2, n_f2;
    logic [9:0]  r_f3, n_f3;
    logic [19:0] r_fm, n_fm;
    logic        r_stat, n_stat;
    logic        r_lat_s, n_lat_s;
    logic        r_lon_w, n_lon_w;
    logic        r_mv_w, n_mv_w;

    logic        accept;
    logic        evt_vld;
    t_evt        evt;
    logic [7:0]  c;
    logic [3:0]  d;
    logic [27:0] int_next;
    logic [7:0]  hdr_char;
    logic        clear_acc;
    logic        full;

    assign accept   = i_valid && !o_stall;
    assign o_stall  = full;
    assign c        = i_rx_byte;
    assign d        = 4'(c - 8'h30);
    assign int_next = 28'(r_int) * 28'd10 + 28'(d);

    always_comb begin
        case (r_hidx)
            3'd0:    hdr_char = 8'h47;
            3'd1:    hdr_char = 8'h50;
            3'd2:    hdr_char = 8'h52;
            3'd3:    hdr_char = 8'h4D;
            3'd4:    hdr_char = 8'h43;
            default: hdr_char = 8'h00;
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_hidx    = r_hidx;
        n_hmatch  = r_hmatch;
        n_field   = r_field;
        n_int     = r_int;
        n_point   = r_point;
        n_fdig    = r_fdig;
        n_f1      = r_f1;
        n_f2      = r_f2;
        n_f3      = r_f3;
        n_fm      = r_fm;
        n_stat    = r_stat;
        n_lat_s   = r_lat_s;
        n_lon_w   = r_lon_w;
        n_mv_w    = r_mv_w;
        clear_acc = 1'b0;
        evt_vld   = 1'b0;
        evt       = '0;
        evt.field = r_field;
        evt.int_v = r_int;
        evt.f1    = r_f1;
        evt.f2    = r_f2;
        evt.f3    = r_f3;
        evt.fm    = r_fm;
        evt.stat  = r_stat;
        evt.lat_s = r_lat_s;
        evt.lon_w = r_lon_w;
        evt.mv_w  = r_mv_w;
        evt.kind  = EV_COMMIT;
        if (c == CH_DOLLAR) begin
            n_phase   = PH_HEAD;
            n_hidx    = '0;
            n_hmatch  = 1'b1;
            n_field   = '0;
            clear_acc = 1'b1;
            n_stat    = 1'b0;
            n_lat_s   = 1'b0;
            n_lon_w   = 1'b0;
            n_mv_w    = 1'b0;
            evt_vld   = 1'b1;
            evt.kind  = EV_CLR;
        end else if (r_phase == PH_HEAD) begin
            if (c == CH_COMMA) begin
                if (r_hidx == 3'd5 && r_hmatch) begin
                    n_phase = PH_FIELDS;
                    n_field = FLD_TIME;
                end else begin
                    n_phase = PH_IDLE;
                end
            end else if (c == CH_LF) begin
                n_phase = PH_IDLE;
            end else begin
                if (r_hidx >= 3'd5 || c != hdr_char) n_hmatch = 1'b0;
                if (r_hidx < 3'd7) n_hidx = r_hidx + 3'd1;
            end
        end else if (r_phase == PH_FIELDS && c != CH_CR) begin
            if (c == CH_COMMA) begin
                evt_vld   = 1'b1;
                clear_acc = 1'b1;
                if (r_field < FLD_IGNORE) n_field = r_field + 4'd1;
            end else if (c == CH_STAR) begin
                evt_vld   = 1'b1;
                clear_acc = 1'b1;
                n_field   = FLD_IGNORE;
            end else if (c == CH_LF) begin
                evt_vld   = 1'b1;
                evt.kind  = EV_EMIT;
                clear_acc = 1'b1;
                n_phase   = PH_IDLE;
            end else begin
                case (r_field)
                    FLD_STATUS: n_stat  = (c != CH_V);
                    FLD_NS:     n_lat_s = (c == CH_S);
                    FLD_EW:     n_lon_w = (c == CH_W);
                    FLD_MAGEW:  n_mv_w  = (c == CH_W);
                    FLD_IGNORE: n_point = r_point;
                    default: begin
                        if (c == CH_DOT) begin
                            n_point = 1'b1;
                        end else if (c inside {[8'h30:8'h39]}) begin
                            if (!r_point) begin
                                n_int = (int_next > 28'(INT_CAP)) ? INT_CAP : int_next[23:0];
                            end else if (int'(r_fdig) < FRAC_LIMIT) begin
                                n_f1   = r_f1 + 4'(frac_add(1, r_fdig, d));
                                n_f2   = r_f2 + 7'(frac_add(2, r_fdig, d));
                                n_f3   = r_f3 + 10'(frac_add(3, r_fdig, d));
                                n_fm   = r_fm + frac_add(MINUTE_DECIMALS, r_fdig, d);
                                n_fdig = r_fdig + 3'd1;
                            end
                        end
                    end
                endcase
            end
        end
        if (clear_acc) begin
            n_int   = '0;
            n_point = 1'b0;
            n_fdig  = '0;
            n_f1    = '0;
            n_f2    = '0;
            n_f3    = '0;
            n_fm    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_hidx   <= '0;
            r_hmatch <= 1'b1;
            r_field  <= '0;
            r_int    <= '0;
            r_point  <= 1'b0;
            r_fdig   <= '0;
            r_f1     <= '0;
            r_f2     <= '0;
            r_f3     <= '0;
            r_fm     <= '0;
            r_stat   <= 1'b0;
            r_lat_s  <= 1'b0;
            r_lon_w  <= 1'b0;
            r_mv_w   <= 1'b0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_hidx   <= n_hidx;
            r_hmatch <= n_hmatch;
            r_field  <= n_field;
            r_int    <= n_int;
            r_point  <= n_point;
            r_fdig   <= n_fdig;
            r_f1     <= n_f1;
            r_f2     <= n_f2;
            r_f3     <= n_f3;
            r_fm     <= n_fm;
            r_stat   <= n_stat;
            r_lat_s  <= n_lat_s;
            r_lon_w  <= n_lon_w;
            r_mv_w   <= n_mv_w;
        end
    end

    rmc_conv u_conv (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_evt_vld        (accept && evt_vld),
        .i_evt            (evt),
        .o_full           (full),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_fix_valid      (o_fix_valid),
        .o_utc_hhmmss     (o_utc_hhmmss),
        .o_date_ddmmyy    (o_date_ddmmyy),
        .o_latitude_udeg  (o_latitude_udeg),
        .o_longitude_udeg (o_longitude_udeg),
        .o_speed_mknots   (o_speed_mknots),
        .o_course_cdeg    (o_course_cdeg),
        .o_magvar_ddeg    (o_magvar_ddeg)
    );

`ifndef NO_ASSERTIONS
    a_fdig_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fdig) <= FRAC_LIMIT)
        else $error("fraction digit count overflow");
    a_fields_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FIELDS) |-> (r_field != 4'd0))
        else $error("field count zero while in fields");
    a_head_to_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == PH_HEAD && c == CH_COMMA && !(r_hidx == 3'd5 && r_hmatch))
        |=> (r_phase == PH_IDLE))
        else $error("bad header accepted");
`endif
endmodule
`default_nettype wire

// ===== test/tb_nmea_rmc_sentence_parser.sv =====
// testbench for the rmc sentence parser: byte stream stimulus, scoreboard with fix predictor
`default_nettype none
module tb_nmea_rmc_sentence_parser;
    import rmc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_POINT  = 8'h2e;

    typedef struct packed {
        logic        fix;
        logic [17:0] utc;
        logic [18:0] date;
        logic [27:0] lat;
        logic [28:0] lon;
        logic [19:0] speed;
        logic [15:0] course;
        logic [11:0] magvar;
    } t_fix;

    class t_fix_scoreboard;
        t_fix pending[$];
        int   mismatches;
        logic [1:0]  phase;
        int          hdr_idx;
        logic        hdr_ok;
        int          fld;
        longint      ip, fp;
        int          fdig;
        logic        pt;
        longint      tv, dv, latm, lonm, spd, crs, mv;
        logic        stat, s_south, s_west, m_west;
        logic [27:0] held_lat;
        logic [28:0] held_lon;

        function void clear_sentence();
            phase = 2'd1; hdr_idx = 0; hdr_ok = 1; fld = 0;
            ip = 0; fp = 0; fdig = 0; pt = 0;
            tv = 0; dv = 0; stat = 0; latm = 0; lonm = 0; s_south = 0; s_west = 0;
            spd = 0; crs = 0; mv = 0; m_west = 0;
        endfunction

        function void reset_state();
            clear_sentence();
            phase = 2'd0; held_lat = 0; held_lon = 0; mismatches = 0;
        endfunction

        function longint scaled_frac(int k);
            longint f;
            int i;
            f = fp;
            for (i = fdig; i > k; i--) f = f / 10;
            for (i = fdig; i < k; i++) f = f * 10;
            return f;
        endfunction

        function longint cap(longint v, longint c);
            return v > c ? c : v;
        endfunction

        function longint fixed_pt(int k, longint c);
            longint s;
            s = 1;
            for (int i = 0; i < k; i++) s = s * 10;
            return cap(ip * s + scaled_frac(k), c);
        endfunction

        function longint to_udeg(longint c);
            longint s, m;
            s = 1;
            for (int i = 0; i < MINUTE_DECIMALS; i++) s = s * 10;
            m = (ip % 100) * s + scaled_frac(MINUTE_DECIMALS);
            return cap((ip / 100) * 1000000 + m * 1000000 / (60 * s), c);
        endfunction

        function void close_field();
            case (fld)
                FLD_TIME:   tv = cap(ip, 235959);
                FLD_LAT:    latm = to_udeg(90000000);
                FLD_LON:    lonm = to_udeg(180000000);
                FLD_SPEED:  spd = fixed_pt(3, 999999);
                FLD_COURSE: crs = fixed_pt(2, 36000);
                FLD_DATE:   dv = cap(ip, 311299);
                FLD_MAGVAR: mv = fixed_pt(1, 1800);
                default: ;
            endcase
            ip = 0; fp = 0; fdig = 0; pt = 0;
        endfunction

        function void note_byte(logic [7:0] c);
            t_fix e;
            string hdr;
            hdr = "GPRMC";
            if (c == CH_DOLLAR) begin
                clear_sentence();
                return;
            end
            if (phase == 2'd1) begin
                if (c == CH_COMMA) begin
                    if (hdr_idx == 5 && hdr_ok) begin
                        phase = 2'd2; fld = 1;
                    end else phase = 2'd0;
                end else if (c == CH_LF) phase = 2'd0;
                else begin
                    if (hdr_idx >= 5 || c != hdr[hdr_idx]) hdr_ok = 0;
                    if (hdr_idx < 7) hdr_idx++;
                end
                return;
            end
            if (phase != 2'd2 || c == CH_CR) return;
            if (c == CH_COMMA) begin
                close_field();
                if (fld < FLD_IGNORE) fld++;
                return;
            end
            if (c == CH_STAR) begin
                close_field();
                fld = FLD_IGNORE;
                return;
            end
            if (c == CH_LF) begin
                close_field();
                phase = 2'd0;
                if (stat) begin
                    held_lat = s_south ? -28'(latm) : 28'(latm);
                    held_lon = s_west ? -29'(lonm) : 29'(lonm);
                end
                e.fix = stat; e.utc = 18'(tv); e.date = 19'(dv);
                e.lat = held_lat; e.lon = held_lon;
                e.speed = 20'(spd); e.course = 16'(crs);
                e.magvar = m_west ? -12'(mv) : 12'(mv);
                pending.push_back(e);
                return;
            end
            case (fld)
                FLD_STATUS: begin stat = (c != "V"); return; end
                FLD_NS:     begin s_south = (c == "S"); return; end
                FLD_EW:     begin s_west = (c == "W"); return; end
                FLD_MAGEW:  begin m_west = (c == "W"); return; end
                FLD_IGNORE: return;
                default: ;
            endcase
            if (c == CH_POINT) pt = 1;
            else if (c >= "0" && c <= "9") begin
                if (!pt) ip = (ip * 10 + (c - "0") > 16777215) ? 16777215 : ip * 10 + (c - "0");
                else if (fdig < FRAC_LIMIT) begin
                    fp = fp * 10 + (c - "0"); fdig++;
                end
            end
        endfunction

        function void check_fix(t_fix got);
            t_fix e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            e = pending.pop_front();
            if (e !== got) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, got);
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0, i_valid = 0, i_stall = 0;
    logic [7:0] i_rx_byte = 0;
    logic o_stall, o_valid, o_fix_valid;
    logic [17:0] o_utc_hhmmss;
    logic [18:0] o_date_ddmmyy;
    logic signed [27:0] o_latitude_udeg;
    logic signed [28:0] o_longitude_udeg;
    logic [19:0] o_speed_mknots;
    logic [15:0] o_course_cdeg;
    logic signed [11:0] o_magvar_ddeg;

    nmea_rmc_sentence_parser u_top (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    t_fix_scoreboard sb = new();
    logic [7:0] byte_q[$];
    int  burst_left = 0;
    int  idle_cycles = 0;
    bit  hold_off = 0;
    bit  long_stall = 0;
    int  stall_mode = 0;
    bit  sending = 0;

    // sender: bursts and gaps, payload held while stalled
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_byte(i_rx_byte);
                void'(byte_q.pop_front());
            end
            if ((i_valid && !o_stall) || !i_valid) begin
                if (byte_q.size() > 0 && !hold_off && (burst_left > 0 || $urandom_range(3) == 0)) begin
                    if (burst_left == 0) burst_left = $urandom_range(40, 1);
                    burst_left--;
                    i_valid <= 1;
                    i_rx_byte <= byte_q[0];
                end else i_valid <= 0;
            end
        end
    end

    // receiver stall pattern and checking
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sb.check_fix({o_fix_valid, o_utc_hhmmss, o_date_ddmmyy, o_latitude_udeg,
                              o_longitude_udeg, o_speed_mknots, o_course_cdeg, o_magvar_ddeg});
            if (long_stall) i_stall <= 1;
            else case (stall_mode)
                0: i_stall <= 0;
                1: i_stall <= ($urandom_range(3) == 0);
                default: i_stall <= ($urandom_range(1) == 0);
            endcase
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("nmea_rmc_sentence_parser regression: fail");
                $finish;
            end
        end
    end

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
    endfunction

    function automatic string digits(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(9)))};
        return s;
    endfunction

    function automatic string rand_num(int ni, int nf);
        string s;
        s = digits(ni);
        if ($urandom_range(4) != 0 && nf >= 0) s = {s, ".", digits(nf)};
        return s;
    endfunction

    function automatic string pick(string a, string b);
        return $urandom_range(1) ? a : b;
    endfunction

    // well-formed sentence with random content; occasional damage
    function automatic void rand_sentence();
        string s;
        s = {"$GPRMC,", rand_num($urandom_range(7), $urandom_range(3)), ",",
             pick(pick("A", "V"), pick("", "X")), ",",
             rand_num($urandom_range(5, 0), $urandom_range(8)), ",", pick("N", pick("S", "")), ",",
             rand_num($urandom_range(6, 0), $urandom_range(8)), ",", pick("E", pick("W", "")), ",",
             rand_num($urandom_range(7), $urandom_range(4)), ",",
             rand_num($urandom_range(6), $urandom_range(3)), ",",
             digits($urandom_range(7)), ",",
             rand_num($urandom_range(5), $urandom_range(2)), ",", pick("E", pick("W", "")),
             pick(pick("*6A", ""), ",,9,x"), pick("\r\n", "\n")};
        if ($urandom_range(9) == 0) s[$urandom_range(s.len() - 1)] = 8'($urandom_range(255));
        if ($urandom_range(14) == 0) s = s.substr(0, $urandom_range(s.len() - 1));
        put_str(s);
    endfunction

    task automatic drain();
        while (byte_q.size() > 0 || sb.pending.size() > 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    initial begin
        sb.reset_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        put_str("$GPRMC,235959.99,A,9000.00000,S,18000.00000,W,999.9999,360.00,311299,180.0,W*00\r\n");
        put_str("$GPRMC,,V,,,,,,,,,*\n");
        put_str("$GPRMC,16777216999,A,8959.999999,N,17959.99999,E,2000,400,999999,999.9,E\n");
        put_str("$GPRMC,12$GPRMC,1.2.3,A,4a0x.5,S,,E,,,,,\n");
        put_str("$GPRMD,1,A\n$GPRMCX,1,A\n$GPR\nGPRMC,1\n");
        put_str({"$GPRMC,1,A,,,,,,,,,,,,,,,,,,\n", "$GPRMC,1,A,9999.99,N,9999.99,W,,,,,\n"});
        byte_q.push_back(8'hff); byte_q.push_back(8'h00);
        drain();
        stall_mode = 1;
        for (int i = 0; i < 12; i++) rand_sentence();
        long_stall = 1;
        fork
            begin repeat (400) @(posedge i_clk); long_stall = 0; end
        join_none
        drain();
        for (int p = 0; p < 3; p++) begin
            stall_mode = p;
            for (int i = 0; i < 4; i++) begin
                if ($urandom_range(5) == 0) begin
                    for (int j = 0; j < 8; j++) byte_q.push_back(8'($urandom_range(255)));
                end else rand_sentence();
            end
            drain();
        end
        hold_off = 1;
        repeat (20) @(posedge i_clk);
        hold_off = 0;
        drain();
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("nmea_rmc_sentence_parser regression: pass");
        else
            $display("nmea_rmc_sentence_parser regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/rmc_pkg.sv
rtl/rmc_conv.sv
rtl/nmea_rmc_sentence_parser.sv
test/tb_nmea_rmc_sentence_parser.sv
